@@ sv/ftpi_pkg.sv @@
package ftpi_pkg;

    localparam int FORCE_W = 16;
    localparam int PWM_W   = 11;
    localparam int CFG_W   = 9;
    localparam int NUM_W   = 28;   // |(f - x1) * (y2 - y1)| < 2^27
    localparam int DEN_W   = 17;   // |x2 - x1| <= 65535

    localparam logic       CMD_WRITE   = 1'b0;
    localparam logic       CMD_CONVERT = 1'b1;

    localparam logic [1:0] STAT_INTERP  = 2'd0;
    localparam logic [1:0] STAT_LOW     = 2'd1;
    localparam logic [1:0] STAT_HIGH    = 2'd2;
    localparam logic [1:0] STAT_WRITTEN = 2'd3;

    localparam logic [PWM_W-1:0] PWM_LOW_CLAMP  = 11'd1100;
    localparam logic [PWM_W-1:0] PWM_HIGH_CLAMP = 11'd1896;
    localparam logic [PWM_W-1:0] PWM_MAX        = 11'd2047;

    localparam logic [CFG_W-1:0] POINTS_RESET = 9'd186;

    typedef struct packed {
        logic                      command;
        logic [7:0]                point_index;
        logic signed [FORCE_W-1:0] point_force;
        logic [PWM_W-1:0]          point_pwm;
        logic signed [FORCE_W-1:0] force_req;
    } in_t;

    typedef struct packed {
        logic [PWM_W-1:0] pwm_us;
        logic [1:0]       status;
    } out_t;

    typedef struct packed {
        logic signed [FORCE_W-1:0] force_val;
        logic [PWM_W-1:0]          pwm;
    } point_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

@@ sv/ftpi_div.sv @@
module ftpi_div import ftpi_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] dvd_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // restoring divide, one quotient bit per cycle; quotient shifts into dvd_reg
    assign trial = {rem_reg, dvd_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                dvd_reg  <= req.num;
                den_reg  <= req.den;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                dvd_reg <= {dvd_reg[NUM_W-2:0], ge};
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = dvd_reg;

endmodule

@@ sv/force_to_pwm_interpolator_core.sv @@
// channel  | ports                         | word
// ---------+-------------------------------+----------------------------------------
// input    | s_valid s_ready s_data        | in_t: command, index, force, pwm, force
// result   | m_valid m_ready m_data        | out_t: pwm_us, status
// config   | cfg_valid cfg_ready cfg_data  | points_in_use, always ready
//
// A write word's result goes to the output register via S_DONE. A convert word scans one
// table entry per cycle over the single read port: a clamp result is set in S_DECIDE, an
// exact match reads the nearest entry in S_EXACT, equal neighbor forces give y1 from S_MUL,
// and an interpolated result needs neighbor and pair reads, one multiply, a serial divide.
// s_ready is high only when idle; a result waiting on m_ready holds the next word off only
// until the output register frees. Reset is synchronous; the table itself is not cleared.
module force_to_pwm_interpolator_core import ftpi_pkg::*; #(
    parameter int MAX_POINTS = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_t              s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_t             m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_EXACT, S_NEIGH, S_RD_LO, S_RD_HI, S_GET_HI,
        S_MUL, S_DIV_GO, S_DIV_WAIT, S_SUM, S_DONE
    } state_t;

    point_t mem [MAX_POINTS];
    point_t rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;

    state_t state_reg;
    logic [CFG_W-1:0] points_reg;
    logic m_valid_reg;
    out_t m_data_reg;
    out_t res_reg;

    logic signed [FORCE_W-1:0] force_reg;
    logic [AW-1:0] cnt_reg;
    logic          issue_reg;
    logic          proc_vld_reg;
    logic [AW-1:0] proc_idx_reg;
    logic signed [FORCE_W:0] best_d_reg;
    logic [FORCE_W:0]        best_abs_reg;
    logic [AW-1:0] c_reg;
    logic [AW-1:0] nb_reg;
    logic [AW-1:0] lo_reg;
    logic [AW-1:0] hi_reg;
    logic          lt_first_reg;
    logic          gt_last_reg;
    logic signed [FORCE_W-1:0] x1_reg;
    logic signed [FORCE_W-1:0] x2_reg;
    logic [PWM_W-1:0] y1_reg;
    logic [PWM_W-1:0] y2_reg;
    logic signed [NUM_W:0]   prod_reg;
    logic signed [DEN_W-1:0] den_reg;
    logic                    neg_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [CW-1:0] cnt_ext;
    logic [AW-1:0] n_m1;
    logic signed [FORCE_W:0] f_ext;
    logic signed [FORCE_W:0] d;
    logic [FORCE_W:0]        abs_d;
    logic [AW-1:0] c2;
    logic          plateau;
    logic signed [FORCE_W:0]  dx;
    logic signed [PWM_W:0]    dy;
    logic signed [DEN_W-1:0]  den;
    logic signed [NUM_W:0]    q_s;
    logic signed [NUM_W+1:0]  r_sum;
    logic [PWM_W-1:0]         r_sat;

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i,
                                              input logic [AW-1:0] last);
        return (i == last) ? last : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
        return (i == '0) ? '0 : i - 1'b1;
    endfunction

    // effective last index, points_in_use held to 2..MAX_POINTS
    always_comb begin
        cnt_ext = CW'(points_reg);
        if (cnt_ext < CW'(2))
            n_m1 = AW'(1);
        else if (cnt_ext > CW'(MAX_POINTS))
            n_m1 = AW'(MAX_POINTS - 1);
        else
            n_m1 = AW'(cnt_ext - 1'b1);
    end

    assign f_ext = {force_reg[FORCE_W-1], force_reg};
    assign d     = {rd_data_reg.force_val[FORCE_W-1], rd_data_reg.force_val} - f_ext;
    assign abs_d = d[FORCE_W] ? (FORCE_W+1)'(0) - d : d;

    // nearest point has zero force when f + best_d == 0
    assign plateau = ((f_ext + best_d_reg) == '0) && (rd_data_reg.force_val == '0);
    assign c2      = plateau ? nb_reg : c_reg;

    assign dx  = f_ext - {x1_reg[FORCE_W-1], x1_reg};
    assign dy  = {1'b0, y2_reg} - {1'b0, y1_reg};
    assign den = {x2_reg[FORCE_W-1], x2_reg} - {x1_reg[FORCE_W-1], x1_reg};

    assign q_s   = neg_reg ? (NUM_W+1)'(0) - {1'b0, div_rsp.quot} : {1'b0, div_rsp.quot};
    assign r_sum = {{(NUM_W-PWM_W+2){1'b0}}, y1_reg} + {q_s[NUM_W], q_s};

    always_comb begin
        if (r_sum[NUM_W+1])
            r_sat = '0;
        else if (r_sum > (NUM_W+2)'(PWM_MAX))
            r_sat = PWM_MAX;
        else
            r_sat = r_sum[PWM_W-1:0];
    end

    always_comb begin
        unique case (state_reg)
            S_SCAN:   rd_addr = cnt_reg;
            S_DECIDE: rd_addr = (best_d_reg == '0) ? c_reg :
                                best_d_reg[FORCE_W] ? idx_inc(c_reg, n_m1) : idx_dec(c_reg);
            S_RD_LO:  rd_addr = lo_reg;
            S_RD_HI:  rd_addr = hi_reg;
            default:  rd_addr = c_reg;
        endcase
    end

    assign wr_addr = AW'(s_data.point_index);
    assign wr_en   = s_valid && s_ready && (s_data.command == CMD_WRITE) &&
                     (32'(s_data.point_index) < MAX_POINTS);

    always_ff @(posedge aclk) begin
        if (wr_en)
            mem[wr_addr] <= '{force_val: s_data.point_force, pwm: s_data.point_pwm};
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            points_reg <= POINTS_RESET;
        else if (cfg_valid)
            points_reg <= cfg_data;
    end

    assign div_req.start = (state_reg == S_DIV_GO);
    assign div_req.num   = prod_reg[NUM_W] ? NUM_W'((NUM_W+1)'(0) - prod_reg)
                                           : prod_reg[NUM_W-1:0];
    assign div_req.den   = den_reg[DEN_W-1] ? DEN_W'(0) - den_reg : den_reg;

    ftpi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            issue_reg    <= 1'b0;
            proc_vld_reg <= 1'b0;
        end else begin
            // S_DONE reloads the output register itself
            if (m_valid_reg && m_ready && (state_reg != S_DONE))
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (s_data.command == CMD_WRITE) begin
                            res_reg   <= '{pwm_us: '0, status: STAT_WRITTEN};
                            state_reg <= S_DONE;
                        end else begin
                            force_reg    <= s_data.force_req;
                            cnt_reg      <= '0;
                            issue_reg    <= 1'b1;
                            proc_vld_reg <= 1'b0;
                            state_reg    <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    proc_vld_reg <= issue_reg;
                    proc_idx_reg <= cnt_reg;
                    if (issue_reg) begin
                        if (cnt_reg == n_m1)
                            issue_reg <= 1'b0;
                        else
                            cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (proc_vld_reg) begin
                        // strict less keeps the first of a tie
                        if (proc_idx_reg == '0 || abs_d < best_abs_reg) begin
                            best_d_reg   <= d;
                            best_abs_reg <= abs_d;
                            c_reg        <= proc_idx_reg;
                        end
                        if (proc_idx_reg == '0)
                            lt_first_reg <= d > 0;
                        if (proc_idx_reg == n_m1) begin
                            gt_last_reg  <= d < 0;
                            proc_vld_reg <= 1'b0;
                            state_reg    <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    nb_reg <= rd_addr;
                    if (lt_first_reg) begin
                        res_reg   <= '{pwm_us: PWM_LOW_CLAMP, status: STAT_LOW};
                        state_reg <= S_DONE;
                    end else if (gt_last_reg) begin
                        res_reg   <= '{pwm_us: PWM_HIGH_CLAMP, status: STAT_HIGH};
                        state_reg <= S_DONE;
                    end else if (best_d_reg == '0) begin
                        state_reg <= S_EXACT;
                    end else begin
                        state_reg <= S_NEIGH;
                    end
                end
                S_EXACT: begin
                    res_reg   <= '{pwm_us: rd_data_reg.pwm, status: STAT_INTERP};
                    state_reg <= S_DONE;
                end
                S_NEIGH: begin
                    if (best_d_reg[FORCE_W]) begin
                        lo_reg <= c2;
                        hi_reg <= idx_inc(c2, n_m1);
                    end else begin
                        lo_reg <= idx_dec(c2);
                        hi_reg <= c2;
                    end
                    state_reg <= S_RD_LO;
                end
                S_RD_LO: begin
                    state_reg <= S_RD_HI;
                end
                S_RD_HI: begin
                    x1_reg    <= rd_data_reg.force_val;
                    y1_reg    <= rd_data_reg.pwm;
                    state_reg <= S_GET_HI;
                end
                S_GET_HI: begin
                    x2_reg    <= rd_data_reg.force_val;
                    y2_reg    <= rd_data_reg.pwm;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg <= (NUM_W+1)'(dx) * (NUM_W+1)'(dy);
                    den_reg  <= den;
                    if (den == '0) begin
                        res_reg   <= '{pwm_us: y1_reg, status: STAT_INTERP};
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_DIV_GO;
                    end
                end
                S_DIV_GO: begin
                    neg_reg   <= prod_reg[NUM_W] ^ den_reg[DEN_W-1];
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_rsp.done)
                        state_reg <= S_SUM;
                end
                S_SUM: begin
                    res_reg   <= '{pwm_us: r_sat, status: STAT_INTERP};
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule
